### rtl/efr_pkg.sv
`timescale 1ns / 1ps

package efr_pkg;

  // Frame geometry
  localparam int MAX_BODY = 30;
  localparam int MIN_BODY = 4;
  localparam int CNT_W    = $clog2(MAX_BODY + 1);
  localparam int IDX_W    = $clog2(MAX_BODY);
  localparam int PLEN_W   = 5;

  // Framing bytes
  localparam logic [7:0] FLAG_BYTE = 8'hAA;
  localparam logic [7:0] ESC_BYTE  = 8'hCC;

  // Configuration register indexes
  localparam logic CFG_STATION = 1'b0;
  localparam logic CFG_BCAST   = 1'b1;

  localparam logic [7:0] STATION_RST = 8'd1;
  localparam logic [7:0] BCAST_RST   = 8'd255;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear;       // drop count and sum
    logic store;       // write current byte into the frame store
    logic drain_start; // latch length, rewind read index
    logic rd;          // read payload byte at the read index
    logic adv;         // step the read index
  } efr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_flag;
    logic is_esc;
    logic full;        // store holds MAX_BODY bytes
    logic dest_bad;    // first body byte is a foreign address
    logic frame_good;  // length, source and checksum all pass
    logic idx_last;    // read index is on the final payload byte
  } efr_sts_t;

endpackage

### rtl/efr_if.sv
`timescale 1ns / 1ps

interface efr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efr_out_if;
  logic                      valid;
  logic                      ready;
  logic [7:0]                payload_byte;
  logic [7:0]                src_addr;
  logic [7:0]                dest_addr;
  logic [efr_pkg::PLEN_W-1:0] payload_len;
  logic                      last;
  logic                      addr_conflict;

  modport source (output valid, output payload_byte, output src_addr, output dest_addr,
                  output payload_len, output last, output addr_conflict, input ready);
  modport sink   (input valid, input payload_byte, input src_addr, input dest_addr,
                  input payload_len, input last, input addr_conflict, output ready);
endinterface

### rtl/efr_datapath.sv
`timescale 1ns / 1ps

module efr_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [7:0]                 rx_byte,
  input  efr_pkg::efr_cmd_t          cmd,
  output efr_pkg::efr_sts_t          sts,
  input  logic                       cfg_we,
  input  logic                       cfg_idx,
  input  logic [7:0]                 cfg_wdata,
  output logic [7:0]                 payload_byte,
  output logic [7:0]                 src_addr,
  output logic [7:0]                 dest_addr,
  output logic [efr_pkg::PLEN_W-1:0] payload_len,
  output logic                       last,
  output logic                       addr_conflict
);

  logic [7:0]                station_r;
  logic [7:0]                bcast_r;
  logic [efr_pkg::CNT_W-1:0] count_r;
  logic [15:0]               sum_r;
  logic [7:0]                dest_r;
  logic [7:0]                src_r;
  logic [7:0]                hi_r;
  logic [efr_pkg::CNT_W-1:0] len_r;
  logic [efr_pkg::IDX_W-1:0] idx_r;
  logic [7:0]                rdata_r;
  logic                      conflict_r;
  logic [7:0]                store_mem [efr_pkg::MAX_BODY];
  logic [15:0]               total;
  logic [efr_pkg::CNT_W-1:0] idx_plus1;
  logic [efr_pkg::IDX_W-1:0] rd_addr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= efr_pkg::STATION_RST;
      bcast_r   <= efr_pkg::BCAST_RST;
    end else if (cfg_we) begin
      if (cfg_idx == efr_pkg::CFG_STATION) station_r <= cfg_wdata;
      else                                 bcast_r   <= cfg_wdata;
    end
  end

  // Body count and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (cmd.store) begin
      count_r <= count_r + 1'b1;
      sum_r   <= sum_r + {8'd0, rx_byte};
    end
  end

  // Keep header fields and the most recent byte (checksum high byte at the footer)
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      hi_r <= rx_byte;
      if (count_r == efr_pkg::CNT_W'(0)) dest_r <= rx_byte;
      if (count_r == efr_pkg::CNT_W'(1)) src_r  <= rx_byte;
    end
  end

  // Frame store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store) store_mem[count_r[efr_pkg::IDX_W-1:0]] <= rx_byte;
    if (cmd.rd)    rdata_r <= store_mem[rd_addr];
  end

  assign rd_addr   = efr_pkg::IDX_W'(idx_r + efr_pkg::IDX_W'(2));
  assign idx_plus1 = efr_pkg::CNT_W'(idx_r) + 1'b1;

  // Drain index, length and conflict flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.drain_start) begin
      idx_r <= '0;
    end else if (cmd.adv) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_start) begin
      len_r      <= count_r - efr_pkg::CNT_W'(efr_pkg::MIN_BODY);
      conflict_r <= (src_r == station_r);
    end
  end

  // Checksum: high byte carries weight 0x100, it was summed once already
  assign total = sum_r + {hi_r, 8'd0} - {8'd0, hi_r};

  always_comb begin
    sts.is_flag    = (rx_byte == efr_pkg::FLAG_BYTE);
    sts.is_esc     = (rx_byte == efr_pkg::ESC_BYTE);
    sts.full       = (count_r >= efr_pkg::CNT_W'(efr_pkg::MAX_BODY));
    sts.dest_bad   = (count_r == '0) && (rx_byte != station_r) && (rx_byte != bcast_r);
    sts.frame_good = (count_r > efr_pkg::CNT_W'(efr_pkg::MIN_BODY)) &&
                     (src_r != bcast_r) && (total == 16'd0);
    sts.idx_last   = (idx_plus1 == len_r);
  end

  assign payload_byte  = rdata_r;
  assign src_addr      = src_r;
  assign dest_addr     = dest_r;
  assign payload_len   = efr_pkg::PLEN_W'(len_r);
  assign last          = sts.idx_last;
  assign addr_conflict = conflict_r;

endmodule

### rtl/efr_ctrl.sv
`timescale 1ns / 1ps

module efr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  efr_pkg::efr_sts_t sts,
  output efr_pkg::efr_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_HUNT = 5'b00001,
    ST_BODY = 5'b00010,
    ST_ESC  = 5'b00100,
    ST_READ = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready  = (state_r == ST_HUNT) || (state_r == ST_BODY) || (state_r == ST_ESC);
  assign out_valid = (state_r == ST_EMIT);
  assign accept    = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_HUNT: begin
        if (accept && sts.is_flag) begin
          cmd.clear = 1'b1;
          state_nxt = ST_BODY;
        end
      end
      ST_BODY: begin
        if (accept) begin
          if (sts.is_flag) begin
            cmd.clear = 1'b1;
            if (sts.frame_good) begin
              cmd.drain_start = 1'b1;
              state_nxt       = ST_READ;
            end
          end else if (sts.is_esc) begin
            state_nxt = ST_ESC;
          end else if (sts.full) begin
            state_nxt = ST_HUNT;
          end else begin
            cmd.store = 1'b1;
            if (sts.dest_bad) state_nxt = ST_HUNT;
          end
        end
      end
      ST_ESC: begin
        if (accept) begin
          if (sts.full) begin
            state_nxt = ST_HUNT;
          end else begin
            cmd.store = 1'b1;
            state_nxt = sts.dest_bad ? ST_HUNT : ST_BODY;
          end
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (sts.idx_last) begin
            state_nxt = ST_BODY;
          end else begin
            cmd.adv   = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_HUNT;
    else        state_r <= state_nxt;
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("controller state not one-hot");

  a_no_store_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(cmd.store || cmd.clear))
    else $error("frame store touched while draining");

  a_emit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.rd))
    else $error("item shown without a store read");

  a_drain_on_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_start |-> (accept && sts.is_flag))
    else $error("drain started without a footer");

endmodule

### rtl/escaped_frame_receiver.sv
`timescale 1ns / 1ps

// Channel | Dir | Fields
// in_ch   | in  | rx_byte[7:0]
// out_ch  | out | payload_byte[7:0] src_addr[7:0] dest_addr[7:0] payload_len[4:0]
//         |     | last addr_conflict
// cfg     | in  | cfg_we cfg_idx (0 station, 1 broadcast) cfg_wdata[7:0]
//
// An input byte is taken whenever the receiver is not draining.
// A good footer starts a drain of N payload items, each a store read and
// then an output, during which no input byte is taken.
// Synchronous active-low reset clears the controller, count, sum, read index and
// config; the frame store is not cleared. A stalled output item holds until taken.
module escaped_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  efr_in_if.sink     in_ch,
  efr_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  logic [7:0] cfg_wdata
);

  efr_pkg::efr_cmd_t cmd;
  efr_pkg::efr_sts_t sts;

  efr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  efr_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_byte       (in_ch.rx_byte),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .payload_byte  (out_ch.payload_byte),
    .src_addr      (out_ch.src_addr),
    .dest_addr     (out_ch.dest_addr),
    .payload_len   (out_ch.payload_len),
    .last          (out_ch.last),
    .addr_conflict (out_ch.addr_conflict)
  );

endmodule

### bench/tb_escaped_frame_receiver.sv
`timescale 1ns / 1ps

module tb_escaped_frame_receiver;

  localparam int SETTLE_CYCLES = 8;
  localparam int TOTAL_ITEMS   = 310;
  localparam int CYCLE_LIMIT   = 200000;

  typedef enum logic [1:0] {RX_HUNT, RX_BODY, RX_ESC, RX_DONE} rx_mode_t;

  typedef struct packed {
    logic [7:0]                 payload_byte;
    logic [7:0]                 src_addr;
    logic [7:0]                 dest_addr;
    logic [efr_pkg::PLEN_W-1:0] payload_len;
    logic                       last;
    logic                       addr_conflict;
  } payload_item_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_idx;
  logic [7:0] cfg_wdata;

  efr_in_if  in_ch ();
  efr_out_if out_ch ();

  escaped_frame_receiver i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Receiver state as the block should hold it
  rx_mode_t                  rx_mode;
  logic [efr_pkg::CNT_W-1:0] body_count;
  logic [15:0]               body_sum;
  logic [7:0]                body_store [efr_pkg::MAX_BODY];
  logic [7:0]                own_addr;
  logic [7:0]                bcast_addr;

  payload_item_t        expected_payload [$];
  payload_item_t        want;
  logic [7:0]           body_q [$];
  int                   mismatches;
  int                   items_taken;
  int                   cycle_count;
  bit                   idle_on;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_escaped_frame_receiver NOT OK");
      $finish;
    end
  end

  // Close a frame on a flag: queue the payload items of a good frame
  function automatic void close_frame();
    logic [7:0]                hi;
    logic [15:0]               total;
    logic [efr_pkg::CNT_W-1:0] len;
    payload_item_t             it;
    if (body_count > efr_pkg::MIN_BODY && body_count <= efr_pkg::MAX_BODY) begin
      rx_mode = RX_DONE;
      if (body_store[1] != bcast_addr) begin
        hi    = body_store[body_count - 1];
        total = body_sum + {hi, 8'h00} - {8'h00, hi};
        if (total == 16'h0000) begin
          len = efr_pkg::CNT_W'(body_count - efr_pkg::MIN_BODY);
          for (int i = 0; i < len; i++) begin
            it.payload_byte  = body_store[2 + i];
            it.src_addr      = body_store[1];
            it.dest_addr     = body_store[0];
            it.payload_len   = efr_pkg::PLEN_W'(len);
            it.last          = (i + 1 == len);
            it.addr_conflict = (body_store[1] == own_addr);
            expected_payload.push_back(it);
          end
        end
      end
    end else begin
      rx_mode = RX_BODY;
    end
    body_count = '0;
    body_sum   = '0;
  endfunction

  // Store one body byte; drop it and hunt on overflow, keep it and hunt on a foreign destination
  function automatic void store_body(input logic [7:0] b);
    rx_mode = RX_BODY;
    if (body_count >= efr_pkg::MAX_BODY) begin
      rx_mode = RX_HUNT;
    end else begin
      body_store[body_count] = b;
      body_count = body_count + 1'b1;
      body_sum   = body_sum + 16'(b);
      if (body_count == 1 && b != own_addr && b != bcast_addr) rx_mode = RX_HUNT;
    end
  endfunction

  // Advance the receiver by one accepted byte
  function automatic void predict_rx(input logic [7:0] b);
    case (rx_mode)
      RX_HUNT: begin
        if (b == efr_pkg::FLAG_BYTE) begin
          rx_mode    = RX_BODY;
          body_count = '0;
          body_sum   = '0;
        end
      end
      RX_ESC: begin
        store_body(b);
      end
      default: begin
        if (b == efr_pkg::FLAG_BYTE) close_frame();
        else if (b == efr_pkg::ESC_BYTE) rx_mode = RX_ESC;
        else store_body(b);
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] got,
                                      input logic [7:0] exp);
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h got %h", $time, name, exp, got);
    end
  endfunction

  // Compare each taken payload item with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_payload.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: payload item %h with nothing expected", $time, out_ch.payload_byte);
      end else begin
        want = expected_payload.pop_front();
        check_field("payload_byte", out_ch.payload_byte, want.payload_byte);
        check_field("src_addr", out_ch.src_addr, want.src_addr);
        check_field("dest_addr", out_ch.dest_addr, want.dest_addr);
        check_field("payload_len", 8'(out_ch.payload_len), 8'(want.payload_len));
        check_field("last", 8'(out_ch.last), 8'(want.last));
        check_field("addr_conflict", 8'(out_ch.addr_conflict), 8'(want.addr_conflict));
      end
    end
  end

  // Stall the result side in random bursts
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Send one byte, with an occasional gap before it, and hold until taken
  task automatic send_item(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_taken++;
    predict_rx(b);
  endtask

  task automatic send_escaped(input logic [7:0] b);
    if (b == efr_pkg::FLAG_BYTE || b == efr_pkg::ESC_BYTE) send_item(efr_pkg::ESC_BYTE);
    send_item(b);
  endtask

  // Hold the sender until every payload item is back and the block is quiet
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (expected_payload.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == efr_pkg::CFG_STATION) own_addr = val;
    else bcast_addr = val;
  endtask

  // Start a body with its two header bytes
  task automatic start_body(input logic [7:0] dest, input logic [7:0] src);
    body_q.delete();
    body_q.push_back(dest);
    body_q.push_back(src);
  endtask

  // Payload data leaning towards the framing bytes
  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 7))
      0:       return efr_pkg::FLAG_BYTE;
      1:       return efr_pkg::ESC_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  // Append the little-endian checksum, spoilt on request
  function automatic void add_checksum(input logic sum_ok);
    logic [15:0] total;
    logic [15:0] cs;
    total = '0;
    foreach (body_q[k]) total = total + 16'(body_q[k]);
    cs = 16'h0000 - total;
    if (!sum_ok) cs = cs + 16'($urandom_range(1, 65535));
    body_q.push_back(cs[7:0]);
    body_q.push_back(cs[15:8]);
  endfunction

  task automatic transmit_frame(input logic open_flag);
    if (open_flag) send_item(efr_pkg::FLAG_BYTE);
    foreach (body_q[k]) send_escaped(body_q[k]);
    send_item(efr_pkg::FLAG_BYTE);
  endtask

  task automatic send_frame(input logic [7:0] dest, input logic [7:0] src, input int n,
                            input logic sum_ok);
    start_body(dest, src);
    repeat (n) body_q.push_back(rand_data());
    add_checksum(sum_ok);
    transmit_frame(rx_mode == RX_HUNT || $urandom_range(0, 3) == 0);
  endtask

  task automatic send_broken();
    case ($urandom_range(0, 3))
      0: begin
        // short body
        repeat ($urandom_range(0, 4)) send_escaped(rand_data());
        send_item(efr_pkg::FLAG_BYTE);
      end
      1: send_frame(own_addr, 8'h00, $urandom_range(27, 28), 1'b1);
      2: repeat ($urandom_range(1, 6)) send_item(8'($urandom));
      default: begin
        // escaped flag taken as data, then a real footer
        send_item(own_addr);
        send_item(efr_pkg::ESC_BYTE);
        send_item(efr_pkg::FLAG_BYTE);
        send_item(efr_pkg::FLAG_BYTE);
      end
    endcase
  endtask

  task automatic random_frame();
    int         kind;
    int         n;
    logic [7:0] dest;
    logic [7:0] src;
    kind = $urandom_range(0, 9);
    dest = $urandom_range(0, 1) ? own_addr : bcast_addr;
    src  = ($urandom_range(0, 3) == 0) ? own_addr : 8'($urandom);
    if (src == bcast_addr) src = src ^ 8'h01;
    n = ($urandom_range(0, 7) == 0) ? 26 : $urandom_range(1, 8);
    case (kind)
      6: send_frame(dest, src, n, 1'b0);
      7: send_frame(dest, bcast_addr, n, 1'b1);
      8: begin
        dest = 8'($urandom);
        while (dest == own_addr || dest == bcast_addr) dest = 8'($urandom);
        send_frame(dest, src, n, 1'b1);
      end
      9: send_broken();
      default: send_frame(dest, src, n, 1'b1);
    endcase
  endtask

  task automatic test_directed_cases();
    // stray bytes while hunting
    send_item(8'h00);
    send_item(8'hFF);
    send_item(efr_pkg::ESC_BYTE);
    // escaped source and payload, single payload byte
    start_body(own_addr, efr_pkg::FLAG_BYTE);
    body_q.push_back(efr_pkg::ESC_BYTE);
    add_checksum(1'b1);
    transmit_frame(1'b1);
    // short body
    send_item(own_addr);
    send_item(8'h02);
    send_item(efr_pkg::FLAG_BYTE);
    // broadcast source
    start_body(bcast_addr, bcast_addr);
    body_q.push_back(8'h00);
    add_checksum(1'b1);
    transmit_frame(1'b0);
    // bad checksum
    start_body(own_addr, 8'h02);
    body_q.push_back(8'hFF);
    add_checksum(1'b0);
    transmit_frame(1'b0);
    // broadcast destination, source equal to own address
    start_body(bcast_addr, own_addr);
    body_q.push_back(8'hFF);
    add_checksum(1'b1);
    transmit_frame(1'b0);
    // foreign destination
    start_body(8'h05, 8'h02);
    body_q.push_back(8'h11);
    add_checksum(1'b1);
    transmit_frame(1'b0);
  endtask

  task automatic test_long_frames();
    send_frame(own_addr, 8'h10, 26, 1'b1);
    // hold the sender until the whole burst has drained
    wait_quiet();
    send_frame(bcast_addr, 8'h20, 27, 1'b1);
    send_frame(own_addr, 8'h30, 2, 1'b1);
  endtask

  task automatic test_register_settings();
    logic [7:0] st_list [4];
    logic [7:0] bc_list [4];
    st_list = '{8'h00, 8'hFF, efr_pkg::FLAG_BYTE, efr_pkg::ESC_BYTE};
    bc_list = '{8'hFF, 8'h00, efr_pkg::FLAG_BYTE, 8'h55};
    for (int i = 0; i < 4; i++) begin
      write_reg(efr_pkg::CFG_STATION, st_list[i]);
      write_reg(efr_pkg::CFG_BCAST, bc_list[i]);
      send_frame(own_addr, own_addr, 1, 1'b1);
      send_frame(bcast_addr, own_addr ^ 8'h80, 3, 1'b1);
      random_frame();
    end
  endtask

  task automatic test_random_traffic();
    int frames;
    frames = 0;
    do begin
      // move the addresses now and then, sometimes making them equal
      if (frames % 10 == 9) begin
        write_reg(efr_pkg::CFG_STATION, 8'($urandom));
        write_reg(efr_pkg::CFG_BCAST, ($urandom_range(0, 7) == 0) ? own_addr : 8'($urandom));
      end
      if (items_taken > TOTAL_ITEMS - 60) idle_on = 1'b0;
      random_frame();
      frames++;
    end while (items_taken < TOTAL_ITEMS);
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    cfg_we        <= 1'b0;
    cfg_idx       <= efr_pkg::CFG_STATION;
    cfg_wdata     <= 8'h00;
    rx_mode     = RX_HUNT;
    body_count  = '0;
    body_sum    = '0;
    own_addr    = efr_pkg::STATION_RST;
    bcast_addr  = efr_pkg::BCAST_RST;
    mismatches  = 0;
    items_taken = 0;
    cycle_count = 0;
    idle_on     = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_long_frames();
    test_register_settings();
    test_random_traffic();

    // drain and let the block settle
    in_ch.valid <= 1'b0;
    while (expected_payload.size() != 0) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_payload.size() == 0) begin
      $display("tb_escaped_frame_receiver OK");
    end else begin
      $display("tb_escaped_frame_receiver NOT OK");
    end
    $finish;
  end

endmodule
